// ===== hdl/mct_pkg.sv =====
`timescale 1ns / 1ps

package mct_pkg;

   // default build of the timer
   localparam int MCT_MATCH_CHANNELS = 4;
   localparam int MCT_COUNTER_BITS   = 32;

   localparam int DATA_W      = 32;
   localparam int REG_INDEX_W = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int MAX_CHANNELS = 4;

   // bit positions inside the bus words
   localparam int FLAG_CAPTURE_BIT = 4;
   localparam int CTRL_ACTION_LSB  = 4;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ACT_HOLD   = 2'd0,
      ACT_CLEAR  = 2'd1,
      ACT_SET    = 2'd2,
      ACT_TOGGLE = 2'd3
   } action_type;

   // bus register map
   localparam logic [REG_INDEX_W-1:0] REG_FLAGS   = 4'd0;
   localparam logic [REG_INDEX_W-1:0] REG_COUNTER = 4'd1;
   localparam logic [REG_INDEX_W-1:0] REG_MATCH0  = 4'd2;
   localparam logic [REG_INDEX_W-1:0] REG_MATCH3  = 4'd5;
   localparam logic [REG_INDEX_W-1:0] REG_CONTROL = 4'd6;
   localparam logic [REG_INDEX_W-1:0] REG_CAPTURE = 4'd7;

   // configuration register map
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESCALE_LIMIT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNTER_ENABLE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH_RESET_MASK = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH_IRQ_MASK   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPTURE_RISING   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPTURE_FALLING  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPTURE_IRQ_EN   = 3'd6;

   typedef struct packed {
      logic [1:0]             operation;
      logic [REG_INDEX_W-1:0] reg_index;
      logic [DATA_W-1:0]      write_data;
      logic                   capture_level;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]       read_data;
      logic                    irq;
      logic [MAX_CHANNELS-1:0] match_outputs;
   } rsp_type;

   typedef struct packed {
      logic [DATA_W-1:0]       prescale_limit;
      logic                    counter_enable;
      logic [MAX_CHANNELS-1:0] match_reset_mask;
      logic [MAX_CHANNELS-1:0] match_irq_mask;
      logic                    capture_on_rising;
      logic                    capture_on_falling;
      logic                    capture_irq_enable;
   } cfg_type;

endpackage

// ===== hdl/mct_core.sv =====
`timescale 1ns / 1ps

module mct_core
   import mct_pkg::*;
#(
   parameter int MATCH_CHANNELS = MCT_MATCH_CHANNELS,
   parameter int COUNTER_BITS   = MCT_COUNTER_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   logic [DATA_W-1:0]         prescale_ff, prescale_in;
   logic [COUNTER_BITS-1:0]   count_ff, count_in;
   logic [COUNTER_BITS-1:0]   match_ff [MATCH_CHANNELS];
   logic [COUNTER_BITS-1:0]   match_in [MATCH_CHANNELS];
   logic [MATCH_CHANNELS-1:0] level_ff, level_in;
   logic [1:0]                action_ff [MATCH_CHANNELS];
   logic [1:0]                action_in [MATCH_CHANNELS];
   logic [MATCH_CHANNELS-1:0] mflag_ff, mflag_in;
   logic                      cflag_ff, cflag_in;
   logic [COUNTER_BITS-1:0]   captured_ff, captured_in;
   logic                      last_level_ff, last_level_in;

   logic [COUNTER_BITS-1:0]   count_inc;
   logic [MATCH_CHANNELS-1:0] eq_now, hit;
   logic                      to_zero;
   logic                      edge_hit;
   logic [DATA_W-1:0]         rd;

   // compare against the current count and the incremented count side by side
   always_comb begin
      count_inc = count_ff + 1'b1;
      for (int c = 0; c < MATCH_CHANNELS; c++) begin
         eq_now[c] = (count_ff == match_ff[c]);
      end
      to_zero = |(eq_now & cfg.match_reset_mask[MATCH_CHANNELS-1:0]);
      for (int c = 0; c < MATCH_CHANNELS; c++) begin
         hit[c] = to_zero ? (match_ff[c] == '0) : (match_ff[c] == count_inc);
      end
      edge_hit = (!last_level_ff && req.capture_level && cfg.capture_on_rising) ||
                 (last_level_ff && !req.capture_level && cfg.capture_on_falling);
   end

   always_comb begin
      prescale_in   = prescale_ff;
      count_in      = count_ff;
      level_in      = level_ff;
      mflag_in      = mflag_ff;
      cflag_in      = cflag_ff;
      captured_in   = captured_ff;
      last_level_in = last_level_ff;
      for (int c = 0; c < MATCH_CHANNELS; c++) begin
         match_in[c]  = match_ff[c];
         action_in[c] = action_ff[c];
      end
      rd = '0;

      unique case (op_type'(req.operation))
         OP_TICK: begin
            last_level_in = req.capture_level;
            if (edge_hit) begin
               captured_in = count_ff;
               if (cfg.capture_irq_enable) begin
                  cflag_in = 1'b1;
               end
            end
            if (cfg.counter_enable) begin
               if (prescale_ff >= cfg.prescale_limit) begin
                  prescale_in = '0;
                  count_in    = to_zero ? '0 : count_inc;
                  for (int c = 0; c < MATCH_CHANNELS; c++) begin
                     if (hit[c]) begin
                        if (cfg.match_irq_mask[c]) begin
                           mflag_in[c] = 1'b1;
                        end
                        case (action_type'(action_ff[c]))
                           ACT_CLEAR:  level_in[c] = 1'b0;
                           ACT_SET:    level_in[c] = 1'b1;
                           ACT_TOGGLE: level_in[c] = ~level_ff[c];
                           default:    level_in[c] = level_ff[c];
                        endcase
                     end
                  end
               end else begin
                  prescale_in = prescale_ff + 1'b1;
               end
            end
         end
         OP_READ: begin
            unique case (req.reg_index) inside
               REG_FLAGS: begin
                  rd[MATCH_CHANNELS-1:0] = mflag_ff;
                  rd[FLAG_CAPTURE_BIT]   = cflag_ff;
               end
               REG_COUNTER: rd = DATA_W'(count_ff);
               [REG_MATCH0:REG_MATCH3]: begin
                  for (int c = 0; c < MATCH_CHANNELS; c++) begin
                     if (req.reg_index == REG_INDEX_W'(int'(REG_MATCH0) + c)) begin
                        rd = DATA_W'(match_ff[c]);
                     end
                  end
               end
               REG_CONTROL: begin
                  rd[MATCH_CHANNELS-1:0] = level_ff;
                  for (int c = 0; c < MATCH_CHANNELS; c++) begin
                     rd[CTRL_ACTION_LSB + 2*c +: 2] = action_ff[c];
                  end
               end
               REG_CAPTURE: rd = DATA_W'(captured_ff);
               default: rd = '0;
            endcase
         end
         OP_WRITE: begin
            unique case (req.reg_index) inside
               REG_FLAGS: begin
                  mflag_in = mflag_ff & ~req.write_data[MATCH_CHANNELS-1:0];
                  cflag_in = cflag_ff & ~req.write_data[FLAG_CAPTURE_BIT];
               end
               REG_COUNTER: count_in = req.write_data[COUNTER_BITS-1:0];
               [REG_MATCH0:REG_MATCH3]: begin
                  for (int c = 0; c < MATCH_CHANNELS; c++) begin
                     if (req.reg_index == REG_INDEX_W'(int'(REG_MATCH0) + c)) begin
                        match_in[c] = req.write_data[COUNTER_BITS-1:0];
                     end
                  end
               end
               REG_CONTROL: begin
                  level_in = req.write_data[MATCH_CHANNELS-1:0];
                  for (int c = 0; c < MATCH_CHANNELS; c++) begin
                     action_in[c] = req.write_data[CTRL_ACTION_LSB + 2*c +: 2];
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // report the state as left by this request
   always_comb begin
      rsp.read_data     = rd;
      rsp.irq           = (|mflag_in) | cflag_in;
      rsp.match_outputs = MAX_CHANNELS'(level_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff   <= '0;
         count_ff      <= '0;
         level_ff      <= '0;
         mflag_ff      <= '0;
         cflag_ff      <= 1'b0;
         captured_ff   <= '0;
         last_level_ff <= 1'b0;
         for (int c = 0; c < MATCH_CHANNELS; c++) begin
            match_ff[c]  <= '0;
            action_ff[c] <= '0;
         end
      end else if (advance) begin
         prescale_ff   <= prescale_in;
         count_ff      <= count_in;
         level_ff      <= level_in;
         mflag_ff      <= mflag_in;
         cflag_ff      <= cflag_in;
         captured_ff   <= captured_in;
         last_level_ff <= last_level_in;
         for (int c = 0; c < MATCH_CHANNELS; c++) begin
            match_ff[c]  <= match_in[c];
            action_ff[c] <= action_in[c];
         end
      end
   end

endmodule

// ===== hdl/match_capture_timer_top.sv =====
`timescale 1ns / 1ps
// A request accepted into the request register passes through the timer into the
//   response register, which holds the response until rsp_ready takes it.
// Throughput: one request per cycle while rsp_ready is high, set by the single pass
//   through the timer state between the request register and the response register.
// Reset: synchronous, active high; clears all timer state, configuration and valids.

module match_capture_timer_top
   import mct_pkg::*;
#(
   parameter int MATCH_CHANNELS = MCT_MATCH_CHANNELS,
   parameter int COUNTER_BITS   = MCT_COUNTER_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_payload,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]      csr_wdata
);

   req_type req_ff;
   logic    req_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_valid_ff;
   cfg_type cfg_ff;
   logic    advance;

   // Move the held request into the response register whenever the response
   // slot is empty or being drained this cycle.
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   // Take a new request when the request register is empty or moving on.
   assign req_ready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Configuration registers; the user must write them only while the timer is quiet, the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PRESCALE_LIMIT:   cfg_ff.prescale_limit     <= csr_wdata;
            CSR_COUNTER_ENABLE:   cfg_ff.counter_enable     <= csr_wdata[0];
            CSR_MATCH_RESET_MASK: cfg_ff.match_reset_mask   <= csr_wdata[MAX_CHANNELS-1:0];
            CSR_MATCH_IRQ_MASK:   cfg_ff.match_irq_mask     <= csr_wdata[MAX_CHANNELS-1:0];
            CSR_CAPTURE_RISING:   cfg_ff.capture_on_rising  <= csr_wdata[0];
            CSR_CAPTURE_FALLING:  cfg_ff.capture_on_falling <= csr_wdata[0];
            CSR_CAPTURE_IRQ_EN:   cfg_ff.capture_irq_enable <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Prescaler, counter, match channels and capture all update in one pass.
   mct_core #(
      .MATCH_CHANNELS (MATCH_CHANNELS),
      .COUNTER_BITS   (COUNTER_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (req_ff),
      .cfg     (cfg_ff),
      .rsp     (rsp_in)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== hdl/mct_checker.sv =====
`timescale 1ns / 1ps

module mct_checker
   import mct_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   logic [1:0] pending_ff, pending_in;

   // requests accepted whose responses are not yet taken
   assign pending_in = pending_ff + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without a request");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd2 && !rsp_ready |-> !req_ready)
      else $error("request taken with both stages full");

endmodule

bind match_capture_timer_top mct_checker u_mct_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import mct_pkg::*;

   // operation code the block must ignore
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int RSP_LATENCY     = 2;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int IDLE_PCT        = 37;

   // ------------------------------------------------------------------
   // DUT signals: every input starts at a known value
   // ------------------------------------------------------------------
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0]      csr_wdata = '0;

   match_capture_timer_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the timer: configuration and state
   // ------------------------------------------------------------------
   cfg_type                 timer_cfg = '0;
   logic [DATA_W-1:0]       tmr_prescale = '0;
   logic [DATA_W-1:0]       tmr_count = '0;
   logic [DATA_W-1:0]       tmr_match [MCT_MATCH_CHANNELS];
   logic [11:0]             tmr_ctrl = '0;
   logic [4:0]              tmr_flags = '0;
   logic [DATA_W-1:0]       tmr_capture = '0;
   logic                    tmr_last_level = 1'b0;

   initial begin
      for (int c = 0; c < MCT_MATCH_CHANNELS; c++) tmr_match[c] = '0;
   end

   // responses still owed by the block, oldest first
   rsp_type pending_timer_rsp [$];

   int req_idle_pct = IDLE_PCT;
   int rsp_idle_pct = IDLE_PCT;
   bit rsp_hold_request = 1'b0;
   int rsp_hold_left = 0;
   int stall_cycles = 0;
   int mismatch_count = 0;
   int requests_sent = 0;
   int responses_checked = 0;
   int settings_used = 0;

   // Step the shadow timer by one request and return the response it owes.
   function automatic rsp_type predict_timer(input req_type r);
      rsp_type o;
      logic    rise;
      logic    fall;
      logic    to_zero;
      int      ch;
      o = '0;
      if (r.operation == OP_TICK) begin
         rise = !tmr_last_level && r.capture_level;
         fall = tmr_last_level && !r.capture_level;
         tmr_last_level = r.capture_level;
         // capture takes the count held before this tick's step
         if ((rise && timer_cfg.capture_on_rising) || (fall && timer_cfg.capture_on_falling)) begin
            tmr_capture = tmr_count;
            if (timer_cfg.capture_irq_enable) tmr_flags[FLAG_CAPTURE_BIT] = 1'b1;
         end
         if (timer_cfg.counter_enable) begin
            // at or above the limit (limit may have been lowered): wrap and step
            if (tmr_prescale >= timer_cfg.prescale_limit) begin
               tmr_prescale = '0;
               to_zero = 1'b0;
               for (ch = 0; ch < MCT_MATCH_CHANNELS; ch++)
                  if (timer_cfg.match_reset_mask[ch] && tmr_count == tmr_match[ch])
                     to_zero = 1'b1;
               tmr_count = to_zero ? '0 : tmr_count + 1'b1;
               for (ch = 0; ch < MCT_MATCH_CHANNELS; ch++) begin
                  if (tmr_count == tmr_match[ch]) begin
                     if (timer_cfg.match_irq_mask[ch]) tmr_flags[ch] = 1'b1;
                     case (action_type'(tmr_ctrl[CTRL_ACTION_LSB + 2*ch +: 2]))
                        ACT_CLEAR:  tmr_ctrl[ch] = 1'b0;
                        ACT_SET:    tmr_ctrl[ch] = 1'b1;
                        ACT_TOGGLE: tmr_ctrl[ch] = ~tmr_ctrl[ch];
                        default: ;
                     endcase
                  end
               end
            end else begin
               tmr_prescale = tmr_prescale + 1'b1;
            end
         end
      end else if (r.operation == OP_READ) begin
         if (r.reg_index == REG_FLAGS)
            o.read_data = DATA_W'(tmr_flags);
         else if (r.reg_index == REG_COUNTER)
            o.read_data = tmr_count;
         else if (r.reg_index >= REG_MATCH0 && r.reg_index <= REG_MATCH3)
            o.read_data = tmr_match[2'(r.reg_index - REG_MATCH0)];
         else if (r.reg_index == REG_CONTROL)
            o.read_data = DATA_W'(tmr_ctrl);
         else if (r.reg_index == REG_CAPTURE)
            o.read_data = tmr_capture;
      end else if (r.operation == OP_WRITE) begin
         if (r.reg_index == REG_FLAGS)
            tmr_flags = tmr_flags & ~r.write_data[4:0];
         else if (r.reg_index == REG_COUNTER)
            tmr_count = r.write_data;
         else if (r.reg_index >= REG_MATCH0 && r.reg_index <= REG_MATCH3)
            tmr_match[2'(r.reg_index - REG_MATCH0)] = r.write_data;
         else if (r.reg_index == REG_CONTROL)
            tmr_ctrl = r.write_data[11:0];
         // capture register and unused indexes: nothing changes
      end
      o.irq           = |tmr_flags;
      o.match_outputs = tmr_ctrl[MAX_CHANNELS-1:0];
      return o;
   endfunction

   function automatic req_type make_req(input logic [1:0] op, input logic [REG_INDEX_W-1:0] idx,
                                        input logic [DATA_W-1:0] data, input logic level);
      req_type r;
      r.operation     = op;
      r.reg_index     = idx;
      r.write_data    = data;
      r.capture_level = level;
      return r;
   endfunction

   function automatic cfg_type make_cfg(input logic [DATA_W-1:0] limit, input logic enable,
                                        input logic [3:0] reset_mask, input logic [3:0] irq_mask,
                                        input logic rising, input logic falling,
                                        input logic capture_irq);
      cfg_type c;
      c.prescale_limit     = limit;
      c.counter_enable     = enable;
      c.match_reset_mask   = reset_mask;
      c.match_irq_mask     = irq_mask;
      c.capture_on_rising  = rising;
      c.capture_on_falling = falling;
      c.capture_irq_enable = capture_irq;
      return c;
   endfunction

   // ------------------------------------------------------------------
   // Request side: idle at random, then hold valid until the request is taken.
   // Valid is only lowered in an idle cycle, so back-to-back requests never
   // see a low and a high scheduled in the same step.
   // ------------------------------------------------------------------
   task automatic send_request(input req_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_timer_rsp.push_back(predict_timer(r));
      requests_sent++;
   endtask

   // Drop valid and wait until every owed response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_timer_rsp.size() != 0) @(posedge clock);
      repeat (RSP_LATENCY) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Write every configuration register, only once the block is idle.
   task automatic load_config(input cfg_type c);
      drain_responses();
      csr_write(CSR_PRESCALE_LIMIT,   c.prescale_limit);
      csr_write(CSR_COUNTER_ENABLE,   DATA_W'(c.counter_enable));
      csr_write(CSR_MATCH_RESET_MASK, DATA_W'(c.match_reset_mask));
      csr_write(CSR_MATCH_IRQ_MASK,   DATA_W'(c.match_irq_mask));
      csr_write(CSR_CAPTURE_RISING,   DATA_W'(c.capture_on_rising));
      csr_write(CSR_CAPTURE_FALLING,  DATA_W'(c.capture_on_falling));
      csr_write(CSR_CAPTURE_IRQ_EN,   DATA_W'(c.capture_irq_enable));
      csr_we <= 1'b0;
      @(posedge clock);
      timer_cfg = c;
      settings_used++;
   endtask

   // ------------------------------------------------------------------
   // Response side: random stalls, plus a long hold-off on request,
   // counted down here so the sender can keep pushing meanwhile.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_hold_request) begin
         rsp_hold_left    = HOLD_OFF_CYCLES;
         rsp_hold_request = 1'b0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_timer_rsp.size() == 0) begin
            $error("unexpected response: read_data %h irq %b match_outputs %b",
                   rsp_payload.read_data, rsp_payload.irq, rsp_payload.match_outputs);
            mismatch_count++;
         end else begin
            want = pending_timer_rsp.pop_front();
            responses_checked++;
            if (rsp_payload.read_data !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data, rsp_payload.read_data);
               mismatch_count++;
            end
            if (rsp_payload.irq !== want.irq) begin
               $error("irq: expected %b, got %b", want.irq, rsp_payload.irq);
               mismatch_count++;
            end
            if (rsp_payload.match_outputs !== want.match_outputs) begin
               $error("match_outputs: expected %b, got %b",
                      want.match_outputs, rsp_payload.match_outputs);
               mismatch_count++;
            end
         end
      end
   end

   // Abort if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Matches at the wrap, every output action, captures on both edges,
   // reads of every register but match 1..3, flag clearing and the ignored writes.
   task automatic test_directed_ops();
      load_config(make_cfg(32'd0, 1'b1, 4'h0, 4'hF, 1'b1, 1'b1, 1'b1));
      send_request(make_req(OP_WRITE, REG_MATCH0,     32'hFFFF_FFFF, 1'b0));
      send_request(make_req(OP_WRITE, REG_INDEX_W'(REG_MATCH0 + 1), 32'h0000_0000, 1'b0));
      send_request(make_req(OP_WRITE, REG_INDEX_W'(REG_MATCH0 + 2), 32'h0000_0002, 1'b0));
      send_request(make_req(OP_WRITE, REG_MATCH3,     32'h0000_0001, 1'b0));
      // toggle, set, clear, hold on channels 0..3; junk above bit 11 must drop
      send_request(make_req(OP_WRITE, REG_CONTROL,
                            32'hFFFF_F000 | DATA_W'({ACT_HOLD, ACT_CLEAR, ACT_SET, ACT_TOGGLE,
                                                     4'b0100}), 1'b0));
      send_request(make_req(OP_WRITE, REG_COUNTER,    32'hFFFF_FFFE, 1'b0));
      // step through the wrap while toggling the capture pin
      send_request(make_req(OP_TICK,  REG_FLAGS, 32'h0, 1'b0));
      send_request(make_req(OP_TICK,  REG_FLAGS, 32'h0, 1'b1));
      send_request(make_req(OP_TICK,  REG_FLAGS, 32'h0, 1'b0));
      send_request(make_req(OP_TICK,  REG_FLAGS, 32'h0, 1'b1));
      send_request(make_req(OP_READ,  REG_FLAGS,   32'h0, 1'b0));
      send_request(make_req(OP_READ,  REG_COUNTER, 32'h0, 1'b0));
      send_request(make_req(OP_READ,  REG_MATCH0,  32'h0, 1'b0));
      send_request(make_req(OP_READ,  REG_CONTROL, 32'h0, 1'b0));
      send_request(make_req(OP_READ,  REG_CAPTURE, 32'h0, 1'b0));
      send_request(make_req(OP_READ,  4'd15,       32'h0, 1'b0));
      // clear some flags only, then check the rest stay
      send_request(make_req(OP_WRITE, REG_FLAGS,   32'h0000_0015, 1'b0));
      send_request(make_req(OP_READ,  REG_FLAGS,   32'h0, 1'b0));
      // capture register is read only, unused index and operation do nothing
      send_request(make_req(OP_WRITE, REG_CAPTURE, 32'h1234_5678, 1'b1));
      send_request(make_req(OP_READ,  REG_CAPTURE, 32'h0, 1'b0));
      send_request(make_req(OP_WRITE, 4'd15,       32'hFFFF_FFFF, 1'b1));
      send_request(make_req(OP_UNUSED, REG_COUNTER, 32'hFFFF_FFFF, 1'b1));
   endtask

   // Lower the prescale limit below the running prescaler, then capture
   // with the counter switched off.
   task automatic test_prescaler_and_capture();
      load_config(make_cfg(32'd5, 1'b1, 4'h0, 4'h0, 1'b1, 1'b1, 1'b0));
      repeat (3) send_request(make_req(OP_TICK, REG_FLAGS, 32'h0, 1'b0));
      load_config(make_cfg(32'd1, 1'b1, 4'h0, 4'h0, 1'b1, 1'b1, 1'b0));
      repeat (3) send_request(make_req(OP_TICK, REG_FLAGS, 32'h0, 1'b0));
      send_request(make_req(OP_READ, REG_COUNTER, 32'h0, 1'b0));
      load_config(make_cfg(32'd0, 1'b0, 4'h0, 4'h0, 1'b1, 1'b0, 1'b1));
      send_request(make_req(OP_TICK, REG_FLAGS, 32'h0, 1'b1));
      send_request(make_req(OP_TICK, REG_FLAGS, 32'h0, 1'b0));
      send_request(make_req(OP_READ, REG_CAPTURE, 32'h0, 1'b0));
      send_request(make_req(OP_READ, REG_FLAGS,   32'h0, 1'b0));
   endtask

   // Mostly ticks with writes steered near the live count so matches and
   // resets really happen; the rest reads, random writes and noise.
   task automatic test_random_phase(input cfg_type c, input int count, input int idle,
                                    input int hold_at, input int pause_at);
      req_type r;
      int      pick;
      load_config(c);
      req_idle_pct = idle;
      rsp_idle_pct = idle;
      for (int i = 0; i < count; i++) begin
         if (i == hold_at) rsp_hold_request = 1'b1;
         if (i == pause_at) drain_responses();
         r.capture_level = 1'($urandom_range(1));
         r.write_data    = $urandom;
         r.reg_index     = ($urandom_range(3) == 0) ? REG_INDEX_W'($urandom_range(15))
                                                    : REG_INDEX_W'($urandom_range(7));
         pick = $urandom_range(99);
         if (pick < 58)      r.operation = OP_TICK;
         else if (pick < 78) r.operation = OP_READ;
         else if (pick < 97) r.operation = OP_WRITE;
         else                r.operation = OP_UNUSED;
         if (r.operation == OP_WRITE) begin
            case ($urandom_range(3))
               0: r.write_data = tmr_count + $urandom_range(6);
               1: r.write_data = tmr_match[2'($urandom_range(MCT_MATCH_CHANNELS - 1))]
                                 - $urandom_range(4);
               2: r.write_data = 32'hFFFF_FFFF - $urandom_range(3);
               default: ;
            endcase
         end
         send_request(r);
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_ops();
      test_prescaler_and_capture();

      // fastest prescale, match flags on, rising captures
      test_random_phase(make_cfg(32'd0, 1'b1, 4'h0, 4'hF, 1'b1, 1'b0, 1'b1),
                        250, IDLE_PCT, -1, -1);
      // long receiver hold-off fills the block while requests keep coming
      test_random_phase(make_cfg(32'd1, 1'b1, 4'h5, 4'hA, 1'b0, 1'b1, 1'b0),
                        250, IDLE_PCT, 100, -1);
      // no idling on either side, every reset and flag enabled
      test_random_phase(make_cfg(32'd0, 1'b1, 4'hF, 4'hF, 1'b1, 1'b1, 1'b1),
                        250, 0, -1, -1);
      // largest limit: counter never steps; sender pauses mid-phase
      test_random_phase(make_cfg(32'hFFFF_FFFF, 1'b1, 4'($urandom), 4'($urandom),
                                 1'b1, 1'b1, 1'b1),
                        250, IDLE_PCT, -1, 120);
      // counter off: only bus traffic and captures change state
      test_random_phase(make_cfg(32'd3, 1'b0, 4'hF, 4'hF, 1'b1, 1'b1, 1'b1),
                        250, IDLE_PCT, -1, -1);
      test_random_phase(make_cfg($urandom_range(2), 1'b1, 4'($urandom), 4'($urandom),
                                 1'($urandom), 1'($urandom), 1'($urandom)),
                        250, IDLE_PCT, -1, -1);

      drain_responses();
      $display("tb: %0d requests sent, %0d responses checked, %0d mismatches",
               requests_sent, responses_checked, mismatch_count);
      $display("tb: %0d timer settings, incl. stalled receiver and paused sender",
               settings_used);
      if (mismatch_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
